@@ sv/swarq_pkg.sv @@
// Shared types, constants and helpers of the sliding-window ARQ sender.
`default_nettype none

package swarq_pkg;

  // Default geometry of the sequence space and the send window.
  localparam int SEQ_SPACE_DEF = 16;
  localparam int WINDOW_DEF    = 8;

  // Most results one tick may produce.
  localparam int MAX_RESULTS = 8;

  // Depths of the command queue and the result queue.
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // Configuration port geometry and register indexes.
  localparam int   PADDR_W       = 3;
  localparam logic REG_ARQ_MODE  = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2;

  // Input item kinds.
  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_PKT  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_SENT    = 3'd0,
    ST_FULL    = 3'd1,
    ST_ACKED   = 3'd2,
    ST_IGNORED = 3'd3,
    ST_CORRUPT = 3'd4,
    ST_RETX    = 3'd5
  } status_e;

  // Classified operations handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_SEND,
    OP_CORRUPT,
    OP_NOACK,
    OP_ACK,
    OP_TICK,
    OP_UNKNOWN
  } op_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] payload_handle;
    logic [3:0]  ack_seq;
    logic        is_ack;
    logic        corrupt_flag;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  tx_seq;
    logic [31:0] tx_payload;
    logic        last;
  } result_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] payload;
    logic [3:0]  ack;
  } cmd_t;

  typedef struct packed {
    logic        arq_mode;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Builds a result that is not yet marked as the last one.
  function automatic result_t mk_res(input status_e st, input logic [3:0] seq,
                                     input logic [31:0] pay);
    result_t r;
    r.status     = st;
    r.tx_seq     = seq;
    r.tx_payload = pay;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/swarq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swarq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/swarq_fifo.sv @@
// Small first-in first-out queue in flip-flops.
`default_nettype none

module swarq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/swarq_front.sv @@
// Front end: accepts input transactions and classifies them into commands.
`default_nettype none

module swarq_front (
  input  wire logic                push_i,
  input  wire swarq_pkg::in_item_t item_i,
  input  wire logic                cmd_full_i,
  output logic                     full_o,
  output logic                     cmd_push_o,
  output swarq_pkg::cmd_t          cmd_o
);

  import swarq_pkg::*;

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i & ~cmd_full_i;

  // Classify by kind; packet flags that need no state are resolved here.
  always_comb begin
    cmd_o.payload = item_i.payload_handle;
    cmd_o.ack     = item_i.ack_seq;
    unique case (item_i.kind)
      KIND_SEND: cmd_o.op = OP_SEND;
      KIND_PKT: begin
        if (item_i.corrupt_flag) begin
          cmd_o.op = OP_CORRUPT;
        end else if (!item_i.is_ack) begin
          cmd_o.op = OP_NOACK;
        end else begin
          cmd_o.op = OP_ACK;
        end
      end
      KIND_TICK: cmd_o.op = OP_TICK;
      default:   cmd_o.op = OP_UNKNOWN;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/swarq_back.sv @@
// Back end: window state, entry memories and the retransmit walk.
`default_nettype none

module swarq_back #(
  parameter int SEQ_SPACE = swarq_pkg::SEQ_SPACE_DEF,
  parameter int WINDOW    = swarq_pkg::WINDOW_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire swarq_pkg::cfg_t cfg_i,
  input  wire logic            cmd_empty_i,
  input  wire swarq_pkg::cmd_t cmd_i,
  output logic                 cmd_pop_o,
  input  wire logic            res_full_i,
  output logic                 res_push_o,
  output swarq_pkg::result_t   res_o
);

  import swarq_pkg::*;

  localparam int SEQ_W   = $clog2(SEQ_SPACE);
  localparam int WIN_LIM = (WINDOW > SEQ_SPACE - 1) ? SEQ_SPACE - 1 : WINDOW;
  localparam int N_W     = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLIDE,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e               state_q, state_d;
  logic [SEQ_W-1:0]     base_q, base_d;
  logic [SEQ_W-1:0]     next_q, next_d;
  logic [31:0]          now_q, now_d;
  logic [SEQ_SPACE-1:0] acked_q, acked_d;
  logic [SEQ_W-1:0]     walk_q, walk_d;
  logic [SEQ_W-1:0]     cnt_q, cnt_d;
  logic [SEQ_W-1:0]     idx_q, idx_d;
  logic [N_W-1:0]       n_q, n_d;
  result_t              pend_q, pend_d;
  logic                 pend_v_q, pend_v_d;

  logic                 pay_we, st_we;
  logic [SEQ_W-1:0]     st_waddr;
  logic [31:0]          pay_rdata, st_rdata;
  logic [SEQ_W-1:0]     outst, ack_s, off;
  logic                 win_full, ack_ok, in_win, stale;
  logic                 gbn_abort, hit, stall, walk_end;
  logic [N_W-1:0]       n_next;

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s == SEQ_W'(SEQ_SPACE - 1)) ? '0 : s + 1'b1;
  endfunction

  // Distance from b forward to a, modulo the sequence space.
  function automatic logic [SEQ_W-1:0] seq_diff(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + (SEQ_W + 1)'(SEQ_SPACE) - {1'b0, b};
    end
    return t[SEQ_W-1:0];
  endfunction

  // Payload handles, written when an entry is sent.
  swarq_ram #(.WIDTH(32), .DEPTH(SEQ_SPACE)) u_pay_ram (
    .clk_i  (clk_i),
    .we_i   (pay_we),
    .waddr_i(next_q),
    .wdata_i(cmd_i.payload),
    .raddr_i(walk_d),
    .rdata_o(pay_rdata)
  );

  // Send stamps, written on send and on retransmit.
  swarq_ram #(.WIDTH(32), .DEPTH(SEQ_SPACE)) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(now_q),
    .raddr_i(walk_d),
    .rdata_o(st_rdata)
  );

  // Window checks shared by the state machine.
  assign outst    = seq_diff(next_q, base_q);
  assign win_full = (outst >= SEQ_W'(WIN_LIM));
  assign ack_s    = SEQ_W'(cmd_i.ack);
  assign ack_ok   = (int'(cmd_i.ack) < SEQ_SPACE);
  assign off      = seq_diff(ack_s, base_q);
  assign in_win   = ack_ok && (off < outst);
  assign stale    = ((now_q - st_rdata) > {16'd0, cfg_i.timeout_ticks});

  // Walk decisions for the entry whose memory data is on hand.
  assign gbn_abort = !cfg_i.arq_mode && (idx_q == '0) && !stale;
  assign hit       = cfg_i.arq_mode ? (!acked_q[walk_q] && stale) : 1'b1;
  assign stall     = hit && pend_v_q && res_full_i;
  assign n_next    = hit ? n_q + 1'b1 : n_q;
  assign walk_end  = (((SEQ_W + 1)'(idx_q) + 1'b1) == {1'b0, cnt_q}) ||
                     (n_next == N_W'(MAX_RESULTS));

  // The held result goes out marked last only when flushed.
  always_comb begin
    res_o      = pend_q;
    res_o.last = (state_q == S_FLUSH);
  end

  // Sequencer: one command at a time, held result drains in order.
  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    next_d     = next_q;
    now_d      = now_q;
    acked_d    = acked_q;
    walk_d     = walk_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    n_d        = n_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    pay_we     = 1'b0;
    st_we      = 1'b0;
    st_waddr   = next_q;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          pend_v_d  = 1'b1;
          state_d   = S_FLUSH;
          unique case (cmd_i.op)
            OP_SEND: begin
              if (win_full) begin
                pend_d = mk_res(ST_FULL, 4'(next_q), '0);
              end else begin
                pay_we          = 1'b1;
                st_we           = 1'b1;
                acked_d[next_q] = 1'b0;
                pend_d          = mk_res(ST_SENT, 4'(next_q), cmd_i.payload);
                next_d          = seq_inc(next_q);
              end
            end
            OP_CORRUPT: pend_d = mk_res(ST_CORRUPT, cmd_i.ack, '0);
            OP_NOACK:   pend_d = mk_res(ST_IGNORED, cmd_i.ack, '0);
            OP_ACK: begin
              if (!in_win) begin
                pend_d = mk_res(ST_IGNORED, cmd_i.ack, '0);
              end else if (!cfg_i.arq_mode) begin
                if (ack_s == base_q) begin
                  base_d = seq_inc(base_q);
                  pend_d = mk_res(ST_ACKED, cmd_i.ack, '0);
                end else begin
                  pend_d = mk_res(ST_IGNORED, cmd_i.ack, '0);
                end
              end else begin
                acked_d[ack_s] = 1'b1;
                pend_d         = mk_res(ST_ACKED, cmd_i.ack, '0);
                if (ack_s == base_q) begin
                  state_d = S_SLIDE;
                end
              end
            end
            OP_TICK: begin
              now_d    = now_q + 32'd1;
              cnt_d    = outst;
              idx_d    = '0;
              n_d      = '0;
              walk_d   = base_q;
              pend_v_d = 1'b0;
              state_d  = (outst == '0) ? S_IDLE : S_WALK;
            end
            default: pend_d = mk_res(ST_IGNORED, 4'd0, '0);
          endcase
        end
      end
      S_SLIDE: begin
        // Move the base over consecutive acknowledged entries.
        if ((base_q != next_q) && acked_q[base_q]) begin
          base_d = seq_inc(base_q);
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_WALK: begin
        if (gbn_abort) begin
          state_d = S_FLUSH;
        end else if (!stall) begin
          if (hit) begin
            res_push_o = pend_v_q;
            pend_d     = mk_res(ST_RETX, 4'(walk_q), pay_rdata);
            pend_v_d   = 1'b1;
            st_we      = 1'b1;
            st_waddr   = walk_q;
            n_d        = n_next;
          end
          idx_d  = idx_q + 1'b1;
          walk_d = seq_inc(walk_q);
          if (walk_end) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      base_q   <= '0;
      next_q   <= '0;
      now_q    <= '0;
      acked_q  <= '0;
      walk_q   <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      n_q      <= '0;
      pend_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      next_q   <= next_d;
      now_q    <= now_d;
      acked_q  <= acked_d;
      walk_q   <= walk_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
      pend_q   <= pend_d;
      pend_v_q <= pend_v_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/sliding_window_arq_sender_core.sv @@
// Top level of the sliding-window ARQ sender: queues, back end and registers.
//
// Input transactions enter through push/full and results leave through
// empty/pop; both sides behave as a queue. Each input item yields one
// result, except a tick, which yields zero to eight retransmit results.
// The final result of an item carries last.
// A send request or a received packet is popped in the idle state and its
// result is pushed from the flush state. A Selective-Repeat ACK on the base
// first slides the base over consecutive acknowledged entries. A tick visits
// the outstanding entries (up to the window) and then flushes; with an empty
// window it returns straight to idle. The back-end sequencer visits one entry
// per cycle, unless a full result queue holds it, through the read port of
// the stamp and payload memories.
// A two-entry command queue decouples the front end, so items keep being
// taken while a result waits; a stalled receiver fills the result queue
// and then holds the back end, and finally raises full.
// Reset clears the window, time and acknowledge flags at once, not the stamp
// and payload memories. The user must write the registers at byte address 0
// (mode) and 4 (timeout) through APB only while idle, unchecked by the core.
`default_nettype none

module sliding_window_arq_sender_core #(
  parameter int SEQ_SPACE = swarq_pkg::SEQ_SPACE_DEF,
  parameter int WINDOW    = swarq_pkg::WINDOW_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire swarq_pkg::in_item_t           item_i,
  output logic                               empty,
  input  wire logic                          pop,
  output swarq_pkg::result_t                 result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [swarq_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  import swarq_pkg::*;

  cfg_t                     cfg_q, cfg_d;
  logic                     cfg_wr, reg_idx;
  logic                     cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t                     cmd_wr, cmd_rd;
  logic [$bits(cmd_t)-1:0]  cmd_rdata;
  logic                     res_push, res_full;
  result_t                  res_wr;
  logic [$bits(result_t)-1:0] res_rdata;

  // Configuration registers behind the APB port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      if (reg_idx == REG_ARQ_MODE) begin
        cfg_d.arq_mode = pwdata[0];
      end else begin
        cfg_d.timeout_ticks = pwdata[15:0];
      end
    end
    if (reg_idx == REG_TIMEOUT) begin
      prdata = {16'd0, cfg_q.timeout_ticks};
    end else begin
      prdata = {31'd0, cfg_q.arq_mode};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arq_mode      <= 1'b0;
      cfg_q.timeout_ticks <= TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end classifies and feeds the command queue.
  swarq_front u_front (
    .push_i    (push),
    .item_i    (item_i),
    .cmd_full_i(cmd_full),
    .full_o    (full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_wr)
  );

  swarq_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wr),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rdata),
    .empty_o(cmd_empty)
  );

  assign cmd_rd = cmd_t'(cmd_rdata);

  // Back end carries out one command at a time.
  swarq_back #(.SEQ_SPACE(SEQ_SPACE), .WINDOW(WINDOW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_rd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_wr)
  );

  // Result queue doubles as the output register.
  swarq_fifo #(.WIDTH($bits(result_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_wr),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign result_o = result_t'(res_rdata);

  // The back end must never offer a result the queue cannot take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // A mode write shows up in the register in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (reg_idx == REG_ARQ_MODE)) |=> (cfg_q.arq_mode == $past(pwdata[0])))
    else $error("arq mode register write lost");

  // A timeout write shows up in the register in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (reg_idx == REG_TIMEOUT)) |=>
      (cfg_q.timeout_ticks == $past(pwdata[15:0])))
    else $error("timeout register write lost");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the sliding-window ARQ sender core.
`default_nettype none

module tb;
  import swarq_pkg::*;

  // Geometry and codes used by the predictor and the stimulus.
  localparam int         WIN         = WINDOW_DEF;
  localparam logic [1:0] KIND_OTHER  = 2'd3;
  localparam logic       MODE_GBN    = 1'b0;
  localparam logic       MODE_SR     = 1'b1;
  localparam int         HOLD_CYCLES = 300;
  localparam int         SETTLE      = 30;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         PHASE_ITEMS = 50;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        push    = 1'b0;
  in_item_t    item_i  = '0;
  logic        pop     = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata  = '0;
  logic        full;
  logic        empty;
  result_t     result_o;
  logic [31:0] prdata;
  logic        pready;

  sliding_window_arq_sender_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Free-running clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Items waiting to be offered and results the sender is due to produce.
  in_item_t    offered_items[$];
  result_t     due_results[$];
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  logic        in_acc = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          stall_req = 0;
  int          stall_seen = 0;
  int          stall_left = 0;

  // Shadow of the sender state and its registers.
  logic        cfg_mode;
  logic [15:0] cfg_timeout;
  logic [3:0]  win_base;
  logic [3:0]  win_next;
  logic [31:0] tick_now;
  logic [31:0] stamp_mem[16];
  logic        acked_mem[16];
  logic [31:0] payload_mem[16];

  // Appends one expected result, not yet marked as the final one.
  task automatic emit(input status_e st, input logic [3:0] seq, input logic [31:0] pay);
    result_t r;
    r.status     = st;
    r.tx_seq     = seq;
    r.tx_payload = pay;
    r.last       = 1'b0;
    due_results.push_back(r);
  endtask

  function automatic logic entry_stale(input logic [3:0] s);
    logic [31:0] elapsed;
    elapsed = tick_now - stamp_mem[s];
    return elapsed > {16'd0, cfg_timeout};
  endfunction

  // Works out the results of one accepted item and updates the shadow state.
  task automatic predict_sender_results(input in_item_t it);
    logic [3:0] fill;
    logic [3:0] offs;
    logic [3:0] s;
    int         start_cnt;
    int         i;
    result_t    tail;
    start_cnt = due_results.size();
    fill      = win_next - win_base;
    case (it.kind)
      KIND_SEND: begin
        if (fill >= WIN) begin
          emit(ST_FULL, win_next, '0);
        end else begin
          payload_mem[win_next] = it.payload_handle;
          stamp_mem[win_next]   = tick_now;
          acked_mem[win_next]   = 1'b0;
          emit(ST_SENT, win_next, it.payload_handle);
          win_next = win_next + 4'd1;
        end
      end
      KIND_PKT: begin
        offs = it.ack_seq - win_base;
        if (it.corrupt_flag) begin
          emit(ST_CORRUPT, it.ack_seq, '0);
        end else if (!it.is_ack || offs >= fill) begin
          emit(ST_IGNORED, it.ack_seq, '0);
        end else if (cfg_mode == MODE_GBN) begin
          if (it.ack_seq == win_base) begin
            win_base = win_base + 4'd1;
            emit(ST_ACKED, it.ack_seq, '0);
          end else begin
            emit(ST_IGNORED, it.ack_seq, '0);
          end
        end else begin
          acked_mem[it.ack_seq] = 1'b1;
          if (it.ack_seq == win_base) begin
            while (win_base != win_next && acked_mem[win_base]) win_base = win_base + 4'd1;
          end
          emit(ST_ACKED, it.ack_seq, '0);
        end
      end
      KIND_TICK: begin
        s        = win_base;
        tick_now = tick_now + 32'd1;
        if (cfg_mode == MODE_GBN) begin
          if (fill != 0 && entry_stale(win_base)) begin
            for (i = 0; i < fill && due_results.size() - start_cnt < MAX_RESULTS; i++) begin
              emit(ST_RETX, s, payload_mem[s]);
              stamp_mem[s] = tick_now;
              s = s + 4'd1;
            end
          end
        end else begin
          for (i = 0; i < fill && due_results.size() - start_cnt < MAX_RESULTS; i++) begin
            if (!acked_mem[s] && entry_stale(s)) begin
              emit(ST_RETX, s, payload_mem[s]);
              stamp_mem[s] = tick_now;
            end
            s = s + 4'd1;
          end
        end
      end
      default: emit(ST_IGNORED, 4'd0, '0);
    endcase
    // Flag the final result of this item.
    if (due_results.size() > start_cnt) begin
      tail      = due_results.pop_back();
      tail.last = 1'b1;
      due_results.push_back(tail);
    end
  endtask

  // Compares one accepted result with the oldest expectation.
  task automatic check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      $error("result without expectation: status %0d tx_seq %0d tx_payload %h",
             got.status, got.tx_seq, got.tx_payload);
      err_cnt++;
      return;
    end
    want = due_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      err_cnt++;
    end
    if (got.tx_seq !== want.tx_seq) begin
      $error("tx_seq: expected %0d, actual %0d", want.tx_seq, got.tx_seq);
      err_cnt++;
    end
    if (got.tx_payload !== want.tx_payload) begin
      $error("tx_payload: expected %h, actual %h", want.tx_payload, got.tx_payload);
      err_cnt++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      err_cnt++;
    end
  endtask

  // Sampling at the rising edge: result transactions first, then input ones.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else if (rst_ni) begin
      in_acc <= push && !full;
      if (pop && !empty) check_result(result_o);
      if (push && !full) predict_sender_results(item_i);
    end
  end

  // Input driver: offers the next pending item once the current one is taken.
  always @(negedge clk_i) begin
    if (!push || in_acc) begin
      if (offered_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item_i <= offered_items.pop_front();
        push   <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= HOLD_CYCLES;
      pop        <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop        <= 1'b0;
    end else begin
      pop <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Register write over the APB port; the shadow copy follows it.
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ARQ_MODE) cfg_mode = val[0];
    else cfg_timeout = val[15:0];
  endtask

  task automatic wait_offered();
    while (offered_items.size() != 0 || push) @(posedge clk_i);
  endtask

  // Waits until every expected result is out and a silent tick has surely ended.
  task automatic wait_drained();
    wait_offered();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic in_item_t pkt(input logic [3:0] seq, input logic ack, input logic bad);
    in_item_t it;
    it              = '0;
    it.kind         = KIND_PKT;
    it.ack_seq      = seq;
    it.is_ack       = ack;
    it.corrupt_flag = bad;
    return it;
  endfunction

  function automatic in_item_t simple_item(input logic [1:0] k, input logic [31:0] pay);
    in_item_t it;
    it                = '0;
    it.kind           = k;
    it.payload_handle = pay;
    return it;
  endfunction

  // Builds a run of mostly well-formed traffic around the current window.
  // Returns how many of the items exercise the window rather than noise.
  task automatic gen_chunk(input int n, output int useful);
    logic [3:0] lb;
    logic [3:0] ln;
    logic [3:0] span;
    in_item_t   it;
    int         k;
    int         r;
    lb     = win_base;
    ln     = win_next;
    useful = 0;
    for (k = 0; k < n; k++) begin
      it                = '0;
      it.payload_handle = $urandom;
      r                 = $urandom_range(99);
      span              = ln - lb;
      if (r < 35) begin
        it.kind = KIND_SEND;
        if (span < WIN) ln = ln + 4'd1;
        useful++;
      end else if (r < 65) begin
        it.kind   = KIND_PKT;
        it.is_ack = 1'b1;
        if (span == 0) begin
          it.ack_seq = 4'($urandom);
        end else if (cfg_mode == MODE_GBN || $urandom_range(2) == 0) begin
          it.ack_seq = lb;
          lb         = lb + 4'd1;
        end else begin
          it.ack_seq = lb + 4'($urandom_range(span - 1));
        end
        useful++;
      end else if (r < 88) begin
        it.kind = KIND_TICK;
        useful++;
      end else begin
        // Noise: any kind, any flags, any sequence number.
        it.kind         = 2'($urandom);
        it.ack_seq      = 4'($urandom);
        it.is_ack       = 1'($urandom);
        it.corrupt_flag = 1'($urandom);
      end
      offered_items.push_back(it);
    end
  endtask

  task automatic run_phase(input logic mode, input logic [15:0] tmo,
                           input int unsigned snd_pct, input int unsigned rcv_pct,
                           input logic pressure);
    int counted;
    int got;
    cfg_write(REG_ARQ_MODE, {31'd0, mode});
    cfg_write(REG_TIMEOUT, {16'd0, tmo});
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    counted        = 0;
    // Hold the result side off while items keep coming, so the input stalls.
    if (pressure) begin
      stall_req++;
      gen_chunk(24, got);
      counted += got;
    end
    while (counted < PHASE_ITEMS) begin
      wait_offered();
      gen_chunk($urandom_range(3, 8), got);
      counted += got;
    end
    wait_drained();
  endtask

  initial begin
    int i;
    cfg_mode    = MODE_GBN;
    cfg_timeout = TIMEOUT_RESET;
    win_base    = '0;
    win_next    = '0;
    tick_now    = '0;
    for (i = 0; i < 16; i++) begin
      stamp_mem[i]   = '0;
      acked_mem[i]   = 1'b0;
      payload_mem[i] = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with reset settings: empty window, filling it, each
    // packet case, the unknown kind, and a full-window retransmit burst.
    offered_items.push_back(simple_item(KIND_TICK, '0));
    offered_items.push_back(pkt(4'd0, 1'b1, 1'b0));
    offered_items.push_back(simple_item(KIND_SEND, 32'h0000_0000));
    offered_items.push_back(simple_item(KIND_SEND, 32'hFFFF_FFFF));
    offered_items.push_back(simple_item(KIND_SEND, 32'hA5A5_A5A5));
    offered_items.push_back(simple_item(KIND_SEND, 32'h5A5A_5A5A));
    for (i = 0; i < 5; i++) offered_items.push_back(simple_item(KIND_SEND, $urandom));
    offered_items.push_back(pkt(4'd0, 1'b1, 1'b1));
    offered_items.push_back(pkt(4'd0, 1'b0, 1'b0));
    offered_items.push_back(pkt(4'd3, 1'b1, 1'b0));
    offered_items.push_back(pkt(4'd15, 1'b1, 1'b0));
    offered_items.push_back(in_item_t'{kind: KIND_OTHER, payload_handle: 32'hFFFF_FFFF,
                                       ack_seq: 4'hF, is_ack: 1'b1, corrupt_flag: 1'b1});
    for (i = 0; i < 3; i++) offered_items.push_back(simple_item(KIND_TICK, '0));
    offered_items.push_back(pkt(4'd0, 1'b1, 1'b0));
    offered_items.push_back(pkt(4'd1, 1'b1, 1'b0));
    wait_drained();

    // Random phases over both modes, timeout extremes and idling patterns.
    run_phase(MODE_GBN, 16'd1,     0,  0,  1'b1);
    run_phase(MODE_SR,  16'd1,     77, 0,  1'b0);
    run_phase(MODE_SR,  16'd3,     0,  77, 1'b0);
    run_phase(MODE_GBN, 16'hFFFF,  21, 21, 1'b0);
    run_phase(MODE_SR,  16'd2,     21, 21, 1'b0);
    run_phase(MODE_GBN, 16'd4,     0,  77, 1'b0);

    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
